@@ rtl/fgae_pkg.sv @@
`default_nettype none
package fgae_pkg;

	localparam int DEF_MAX_COLS    = 64;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_GUARD_WIDTH = 1;
	localparam int DEF_FRAC_BITS   = 16;

	// Widths that cover the whole parameter range (grids up to 1024, FRAC_BITS up to 24).
	localparam int IDX_W      = 10;
	localparam int NC_W       = 11;
	localparam int WGT_W      = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam int JOBQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COLS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_R_FLOOR = 3'd4;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic [NC_W-1:0] nc;
		logic [NC_W-1:0] nr;
		logic [30:0]     inv_x;
		logic [30:0]     inv_y;
		logic [30:0]     r_floor;
	} cfg_t;

	typedef struct packed {
		func_t                func;
		logic                 ld_ok;
		logic [11:0]          ld_addr;
		logic signed [31:0]   ld_data;
		logic [IDX_W-1:0]     x0;
		logic [IDX_W-1:0]     x1;
		logic [IDX_W-1:0]     y0;
		logic [IDX_W-1:0]     y1;
		logic [IDX_W-1:0]     gix;
		logic [IDX_W-1:0]     giy;
		logic [WGT_W-1:0]     wx;
		logic [WGT_W-1:0]     wy;
		logic signed [31:0]   vx2;
		logic signed [31:0]   vy2;
		logic                 vsat;
	} job_t;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic               sat;
	} result_t;

	function automatic logic ovf32(input logic signed [65:0] v);
		return (v > 66'sd2147483647) || (v < -66'sd2147483648);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/fgae_ram.sv @@
`default_nettype none
module fgae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

@@ rtl/fgae_fifo.sv @@
`default_nettype none
module fgae_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t din,
	output logic       full,
	input  wire logic  pop,
	output item_t      dout,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/fgae_front.sv @@
`default_nettype none
module fgae_front #(
	parameter int MAX_COLS    = fgae_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS    = fgae_pkg::DEF_MAX_ROWS,
	parameter int GUARD_WIDTH = fgae_pkg::DEF_GUARD_WIDTH,
	parameter int FRAC_BITS   = fgae_pkg::DEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fgae_pkg::cfg_t     cfg,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               func,
	input  wire logic [11:0]        cell_index,
	input  wire logic signed [31:0] sample_value,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	output logic                    q_push,
	output fgae_pkg::job_t          q_data,
	input  wire logic               q_full
);
	import fgae_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] GW   = 64'(GUARD_WIDTH);

	logic               v_s1;
	func_t              func_s1;
	logic [11:0]        idx_s1;
	logic signed [31:0] val_s1;
	logic signed [63:0] px_s1;
	logic signed [63:0] py_s1;
	logic signed [63:0] vx_s1;
	logic signed [63:0] vy_s1;

	logic               accept;
	logic signed [63:0] fx, fy, x0r, y0r, ncm1, nrm1;
	logic signed [63:0] x0c, x1c, y0c, y1c, wxc, wyc, gixc, giyc;
	logic signed [65:0] vxw, vyw;

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		if (v < lo) begin
			return lo;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Nearest grid point, halves rounded away from zero.
	function automatic logic signed [63:0] round_q(input logic signed [63:0] f);
		if (f >= 0) begin
			return (f + HALF) >>> FRAC_BITS;
		end
		return -((-f + HALF) >>> FRAC_BITS);
	endfunction

	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign full   = v_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_t'(func);
			idx_s1  <= cell_index;
			val_s1  <= sample_value;
			px_s1   <= pos_x * $signed({1'b0, cfg.inv_x});
			py_s1   <= pos_y * $signed({1'b0, cfg.inv_y});
			vx_s1   <= vel_x * vel_x;
			vy_s1   <= vel_y * vel_y;
		end
	end

	always_comb begin
		fx   = px_s1 >>> FRAC_BITS;
		fy   = py_s1 >>> FRAC_BITS;
		x0r  = fx >>> FRAC_BITS;
		y0r  = fy >>> FRAC_BITS;
		ncm1 = $signed(64'(cfg.nc)) - 64'sd1;
		nrm1 = $signed(64'(cfg.nr)) - 64'sd1;
		x0c  = clamp64(x0r, 64'sd0, ncm1);
		x1c  = clamp64(x0r + 64'sd1, 64'sd0, ncm1);
		y0c  = clamp64(y0r, 64'sd0, nrm1);
		y1c  = clamp64(y0r + 64'sd1, 64'sd0, nrm1);
		wxc  = clamp64(fx - (x0c <<< FRAC_BITS), 64'sd0, ONE);
		wyc  = clamp64(fy - (y0c <<< FRAC_BITS), 64'sd0, ONE);
		gixc = clamp64(round_q(fx), GW, ncm1 - GW);
		giyc = clamp64(round_q(fy), GW, nrm1 - GW);
		vxw  = {{2{vx_s1[63]}}, vx_s1 >>> FRAC_BITS};
		vyw  = {{2{vy_s1[63]}}, vy_s1 >>> FRAC_BITS};

		q_data.func    = func_s1;
		q_data.ld_ok   = (32'(idx_s1) < 32'(DEPTH));
		q_data.ld_addr = idx_s1;
		q_data.ld_data = val_s1;
		q_data.x0      = x0c[IDX_W-1:0];
		q_data.x1      = x1c[IDX_W-1:0];
		q_data.y0      = y0c[IDX_W-1:0];
		q_data.y1      = y1c[IDX_W-1:0];
		q_data.gix     = gixc[IDX_W-1:0];
		q_data.giy     = giyc[IDX_W-1:0];
		q_data.wx      = wxc[WGT_W-1:0];
		q_data.wy      = wyc[WGT_W-1:0];
		q_data.vx2     = sat32(vxw);
		q_data.vy2     = sat32(vyw);
		q_data.vsat    = ovf32(vxw) || ovf32(vyw);
	end

endmodule
`default_nettype wire

@@ rtl/fgae_back.sv @@
`default_nettype none
module fgae_back #(
	parameter int MAX_COLS  = fgae_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS  = fgae_pkg::DEF_MAX_ROWS,
	parameter int FRAC_BITS = fgae_pkg::DEF_FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fgae_pkg::cfg_t    cfg,
	input  wire logic              q_empty,
	output logic                   q_pop,
	input  wire fgae_pkg::job_t    q_data,
	output logic                   res_push,
	output fgae_pkg::result_t      res_data,
	input  wire logic              res_full
);
	import fgae_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [WGT_W-1:0] ONE_W = WGT_W'(64'd1 << FRAC_BITS);

	// Step numbers: the first eight also issue the eight sample reads in order.
	localparam logic [3:0] K_RD0   = 4'd0;
	localparam logic [3:0] K_MUL0  = 4'd1;
	localparam logic [3:0] K_MUL1  = 4'd2;
	localparam logic [3:0] K_TOP   = 4'd3;
	localparam logic [3:0] K_MUL3  = 4'd4;
	localparam logic [3:0] K_BOT   = 4'd5;
	localparam logic [3:0] K_MULWY = 4'd6;
	localparam logic [3:0] K_R     = 4'd7;
	localparam logic [3:0] K_GX    = 4'd8;
	localparam logic [3:0] K_MULGY = 4'd9;
	localparam logic [3:0] K_GY    = 4'd10;
	localparam logic [3:0] K_RGX   = 4'd11;
	localparam logic [3:0] K_RGY   = 4'd12;
	localparam logic [3:0] K_T1    = 4'd13;
	localparam logic [3:0] K_T2    = 4'd14;

	back_state_t        state_q, state_d;
	logic [3:0]         step_q;
	job_t               job_q;
	logic signed [64:0] p_q, acc_q;
	logic signed [31:0] top_q, bot_q, r_q, e_q;
	logic signed [32:0] d_q;
	logic signed [31:0] gx_q, gy_q, rgx_q, rgy_q, t1_q, t2_q;
	logic               flag_q;

	logic [AW-1:0]      ram_addr;
	logic               ram_we;
	logic [31:0]        ram_rdata;
	logic signed [31:0] rd;
	logic [IDX_W-1:0]   ix, iy;
	logic [IDX_W+NC_W-1:0] lin;
	logic signed [32:0] ma;
	logic signed [31:0] mb;
	logic signed [64:0] prod;
	logic signed [65:0] sum, shf, shg, sx, sy;
	logic signed [31:0] rr;
	logic               start_q, load_w;

	fgae_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (q_data.ld_data),
		.rdata (ram_rdata)
	);

	assign rd   = $signed(ram_rdata);
	assign prod = ma * mb;
	assign sum  = 66'(acc_q) + 66'(p_q);
	assign shf  = 66'(p_q >>> FRAC_BITS);
	assign shg  = 66'(p_q >>> (FRAC_BITS + 1));
	assign rr   = sum[FRAC_BITS+31:FRAC_BITS];
	assign sx   = 66'(rgx_q) - 66'(t1_q) - 66'(t2_q);
	assign sy   = 66'(rgy_q) - 66'(t1_q) - 66'(t2_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty && q_data.func == FUNC_QUERY) begin
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				if (step_q == K_T2) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (!res_full) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		q_pop    = 1'b0;
		load_w   = 1'b0;
		res_push = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_pop  = !q_empty;
				load_w = !q_empty && q_data.func == FUNC_LOAD && q_data.ld_ok;
			end
			B_RUN: begin
			end
			B_DONE: begin
				res_push = !res_full;
			end
			default: begin
			end
		endcase
	end

	assign ram_we  = load_w;
	assign start_q = (state_q == B_IDLE) && !q_empty && q_data.func == FUNC_QUERY;

	always_comb begin
		ix = job_q.x0;
		iy = job_q.y0;
		case (step_q)
			K_RD0: begin
				ix = job_q.x0;
				iy = job_q.y0;
			end
			K_MUL0: begin
				ix = job_q.x1;
				iy = job_q.y0;
			end
			K_MUL1: begin
				ix = job_q.x0;
				iy = job_q.y1;
			end
			K_TOP: begin
				ix = job_q.x1;
				iy = job_q.y1;
			end
			K_MUL3: begin
				ix = job_q.gix + 1'b1;
				iy = job_q.giy;
			end
			K_BOT: begin
				ix = job_q.gix - 1'b1;
				iy = job_q.giy;
			end
			K_MULWY: begin
				ix = job_q.gix;
				iy = job_q.giy + 1'b1;
			end
			K_R: begin
				ix = job_q.gix;
				iy = job_q.giy - 1'b1;
			end
			default: begin
			end
		endcase
		lin = (IDX_W+NC_W)'(iy) * (IDX_W+NC_W)'(cfg.nc) + (IDX_W+NC_W)'(ix);
		if (state_q == B_IDLE) begin
			ram_addr = AW'(q_data.ld_addr);
		end else begin
			ram_addr = AW'(lin);
		end
	end

	// One shared multiplier; its operands follow the step.
	always_comb begin
		ma = '0;
		mb = '0;
		case (step_q)
			K_MUL0, K_TOP: begin
				ma = 33'(rd);
				mb = $signed(32'(ONE_W - job_q.wx));
			end
			K_MUL1, K_MUL3: begin
				ma = 33'(rd);
				mb = $signed(32'(job_q.wx));
			end
			K_BOT: begin
				ma = 33'(top_q);
				mb = $signed(32'(ONE_W - job_q.wy));
			end
			K_MULWY: begin
				ma = 33'(bot_q);
				mb = $signed(32'(job_q.wy));
			end
			K_R: begin
				ma = d_q;
				mb = $signed({1'b0, cfg.inv_x});
			end
			K_MULGY: begin
				ma = d_q;
				mb = $signed({1'b0, cfg.inv_y});
			end
			K_GY: begin
				ma = 33'(r_q);
				mb = gx_q;
			end
			K_RGX: begin
				ma = 33'(r_q);
				mb = gy_q;
			end
			K_RGY: begin
				ma = 33'(rgx_q);
				mb = job_q.vx2;
			end
			K_T1: begin
				ma = 33'(rgy_q);
				mb = job_q.vy2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			job_q  <= q_data;
			flag_q <= q_data.vsat;
		end
		if (state_q == B_RUN) begin
			p_q <= prod;
			case (step_q)
				K_MUL1, K_MUL3, K_MULWY: begin
					acc_q <= p_q;
				end
				K_TOP: begin
					top_q <= rr;
				end
				K_BOT: begin
					bot_q <= rr;
					e_q   <= rd;
				end
				K_R: begin
					r_q <= (rr < $signed({1'b0, cfg.r_floor})) ? $signed({1'b0, cfg.r_floor})
						: rr;
					e_q <= rd;
				end
				K_GX: begin
					gx_q   <= sat32(shg);
					flag_q <= flag_q | ovf32(shg);
				end
				K_GY: begin
					gy_q   <= sat32(shg);
					flag_q <= flag_q | ovf32(shg);
				end
				K_RGX: begin
					rgx_q  <= sat32(shf);
					flag_q <= flag_q | ovf32(shf);
				end
				K_RGY: begin
					rgy_q  <= sat32(shf);
					flag_q <= flag_q | ovf32(shf);
				end
				K_T1: begin
					t1_q   <= sat32(shf);
					flag_q <= flag_q | ovf32(shf);
				end
				K_T2: begin
					t2_q   <= sat32(shf);
					flag_q <= flag_q | ovf32(shf);
				end
				default: begin
				end
			endcase
			// The stencil differences take the sample that arrives after the stored one.
			if (step_q == K_MULWY || step_q == K_GX) begin
				d_q <= 33'(e_q) - 33'(rd);
			end
		end
	end

	assign res_data.ax  = sat32(sx);
	assign res_data.ay  = sat32(sy);
	assign res_data.sat = flag_q | ovf32(sx) | ovf32(sy);

endmodule
`default_nettype wire

@@ rtl/field_geodesic_accel_engine.sv @@
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+----------------------------------------------
// input     | push / full                    | func, cell_index, sample_value, pos/vel x,y
// result    | pop / empty                    | accel_x, accel_y, saturated
// config    | cfg_valid / cfg_ready (always) | cfg_index, cfg_data
//
// The back end does a load while idle; a query holds it until its result is pushed, its run
// set by the eight sample reads from the single-ported field memory and one shared multiplier.
// The front end takes an item every cycle while the two-entry job queue has room.
// Reset clears control state only; field samples are undefined until loaded.
// A stalled result stays at the head of the two-entry result queue.
`default_nettype none
module field_geodesic_accel_engine #(
	parameter int MAX_COLS    = fgae_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS    = fgae_pkg::DEF_MAX_ROWS,
	parameter int GUARD_WIDTH = fgae_pkg::DEF_GUARD_WIDTH,
	parameter int FRAC_BITS   = fgae_pkg::DEF_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              func,
	input  wire logic [11:0]                       cell_index,
	input  wire logic signed [31:0]                sample_value,
	input  wire logic signed [31:0]                pos_x,
	input  wire logic signed [31:0]                pos_y,
	input  wire logic signed [31:0]                vel_x,
	input  wire logic signed [31:0]                vel_y,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic signed [31:0]                     accel_x,
	output logic signed [31:0]                     accel_y,
	output logic                                   saturated,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fgae_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fgae_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fgae_pkg::*;

	logic [6:0]  cols_q, rows_q;
	logic [30:0] inv_x_q, inv_y_q, r_floor_q;
	logic [31:0] nc32, nr32;
	cfg_t        cfg;

	logic    jq_push, jq_full, jq_pop, jq_empty;
	job_t    jq_din, jq_dout;
	logic    res_push, res_full;
	result_t res_din, res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= 7'd64;
			rows_q    <= 7'd64;
			inv_x_q   <= 31'd65536;
			inv_y_q   <= 31'd65536;
			r_floor_q <= 31'd66;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COLS:    cols_q    <= cfg_data[6:0];
				REG_ROWS:    rows_q    <= cfg_data[6:0];
				REG_INV_X:   inv_x_q   <= cfg_data;
				REG_INV_Y:   inv_y_q   <= cfg_data;
				REG_R_FLOOR: r_floor_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		nc32 = 32'(cols_q);
		nr32 = 32'(rows_q);
		if (nc32 < 32'd3) begin
			nc32 = 32'd3;
		end else if (nc32 > 32'(MAX_COLS)) begin
			nc32 = 32'(MAX_COLS);
		end
		if (nr32 < 32'd3) begin
			nr32 = 32'd3;
		end else if (nr32 > 32'(MAX_ROWS)) begin
			nr32 = 32'(MAX_ROWS);
		end
		cfg.nc      = nc32[NC_W-1:0];
		cfg.nr      = nr32[NC_W-1:0];
		cfg.inv_x   = inv_x_q;
		cfg.inv_y   = inv_y_q;
		cfg.r_floor = r_floor_q;
	end

	fgae_front #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.GUARD_WIDTH (GUARD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.push         (push),
		.full         (full),
		.func         (func),
		.cell_index   (cell_index),
		.sample_value (sample_value),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.q_push       (jq_push),
		.q_data       (jq_din),
		.q_full       (jq_full)
	);

	fgae_fifo #(
		.item_t (job_t),
		.DEPTH  (JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (jq_din),
		.full   (jq_full),
		.pop    (jq_pop),
		.dout   (jq_dout),
		.empty  (jq_empty)
	);

	fgae_back #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (jq_empty),
		.q_pop    (jq_pop),
		.q_data   (jq_dout),
		.res_push (res_push),
		.res_data (res_din),
		.res_full (res_full)
	);

	fgae_fifo #(
		.item_t (result_t),
		.DEPTH  (RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_din),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head),
		.empty  (empty)
	);

	assign accel_x   = res_head.ax;
	assign accel_y   = res_head.ay;
	assign saturated = res_head.sat;

	a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_push |-> !jq_full)
		else $error("job queue written while full");

	a_jobq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |-> !jq_empty)
		else $error("job queue read while empty");

	a_resq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue written while full");

endmodule
`default_nettype wire

@@ bench/field_geodesic_accel_engine_test.sv @@
`timescale 1ns / 100ps
module field_geodesic_accel_engine_test;
	import fgae_pkg::*;

	typedef struct {
		func_t              op;
		logic [11:0]        addr;
		logic signed [31:0] sample;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} particle_op_t;

	typedef struct {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic               sat;
	} accel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic func = 1'b0;
	logic [11:0] cell_index = '0;
	logic signed [31:0] sample_value = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] vel_x = '0;
	logic signed [31:0] vel_y = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [31:0] accel_x;
	logic signed [31:0] accel_y;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	field_geodesic_accel_engine dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.cell_index(cell_index), .sample_value(sample_value), .pos_x(pos_x),
		.pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y), .empty(empty), .pop(pop),
		.accel_x(accel_x), .accel_y(accel_y), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the sample store and registers, updated at each transaction.
	logic signed [31:0] field_mirror [0:4095];
	longint grid_cols = 64, grid_rows = 64, scale_x = 65536, scale_y = 65536;
	longint field_min = 66;

	particle_op_t pending_ops[$];
	accel_t expected_accel[$];
	int mismatches = 0;
	bit calm = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sat_word(longint v, ref bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b, ref bit flag);
		return sat_word((a * b) >>> 16, flag);
	endfunction

	function automatic longint nearest_point(longint f);
		if (f >= 0)
			return (f + 32768) >>> 16;
		return -(((-f) + 32768) >>> 16);
	endfunction

	function automatic longint sample_at(longint ix, longint iy, longint nc);
		return longint'(field_mirror[iy * nc + ix]);
	endfunction

	function automatic accel_t predict_accel(particle_op_t it);
		longint nc, nr, fx, fy, x0r, y0r, x0, x1, y0, y1, wx, wy;
		longint top, bot, r, gix, giy, gx, gy, rgx, rgy, vx2, vy2, t1, t2;
		bit flag;
		accel_t res;
		flag = 1'b0;
		nc = clip(grid_cols, 3, 64);
		nr = clip(grid_rows, 3, 64);
		fx = (longint'(it.px) * scale_x) >>> 16;
		fy = (longint'(it.py) * scale_y) >>> 16;
		x0r = fx >>> 16;
		y0r = fy >>> 16;
		x0 = clip(x0r, 0, nc - 1);
		x1 = clip(x0r + 1, 0, nc - 1);
		y0 = clip(y0r, 0, nr - 1);
		y1 = clip(y0r + 1, 0, nr - 1);
		wx = clip(fx - (x0 << 16), 0, 65536);
		wy = clip(fy - (y0 << 16), 0, 65536);
		top = (sample_at(x0, y0, nc) * (65536 - wx) + sample_at(x1, y0, nc) * wx) >>> 16;
		bot = (sample_at(x0, y1, nc) * (65536 - wx) + sample_at(x1, y1, nc) * wx) >>> 16;
		r = (top * (65536 - wy) + bot * wy) >>> 16;
		if (r < field_min)
			r = field_min;
		gix = clip(nearest_point(fx), 1, nc - 2);
		giy = clip(nearest_point(fy), 1, nr - 2);
		gx = sat_word(((sample_at(gix + 1, giy, nc) - sample_at(gix - 1, giy, nc))
			* scale_x) >>> 17, flag);
		gy = sat_word(((sample_at(gix, giy + 1, nc) - sample_at(gix, giy - 1, nc))
			* scale_y) >>> 17, flag);
		rgx = qmul(r, gx, flag);
		rgy = qmul(r, gy, flag);
		vx2 = qmul(longint'(it.vx), longint'(it.vx), flag);
		vy2 = qmul(longint'(it.vy), longint'(it.vy), flag);
		t1 = qmul(rgx, vx2, flag);
		t2 = qmul(rgy, vy2, flag);
		res.ax = 32'(sat_word(rgx - t1 - t2, flag));
		res.ay = 32'(sat_word(rgy - t1 - t2, flag));
		res.sat = flag;
		return res;
	endfunction

	// Input side: hold the head item until the transaction completes.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (push) begin
				if (pending_ops[0].op == FUNC_LOAD)
					field_mirror[pending_ops[0].addr] = pending_ops[0].sample;
				else
					expected_accel.push_back(predict_accel(pending_ops[0]));
				void'(pending_ops.pop_front());
			end
			if (send_gap > 0) begin
				push <= 1'b0;
				send_gap--;
			end else if (pending_ops.size() > 0) begin
				push <= 1'b1;
				func <= pending_ops[0].op;
				cell_index <= pending_ops[0].addr;
				sample_value <= pending_ops[0].sample;
				pos_x <= pending_ops[0].px;
				pos_y <= pending_ops[0].py;
				vel_x <= pending_ops[0].vx;
				vel_y <= pending_ops[0].vy;
				if (!calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 10);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result side.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_accel.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result ax=%0d ay=%0d sat=%0d",
							accel_x, accel_y, saturated);
				end else begin
					if (accel_x !== expected_accel[0].ax || accel_y !== expected_accel[0].ay
						|| saturated !== expected_accel[0].sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected ax=%0d ay=%0d sat=%0d, got ax=%0d ay=%0d sat=%0d",
								expected_accel[0].ax, expected_accel[0].ay,
								expected_accel[0].sat, accel_x, accel_y, saturated);
					end
					void'(expected_accel.pop_front());
				end
			end
			if (recv_gap > 0) begin
				pop <= 1'b0;
				recv_gap--;
			end else begin
				pop <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					recv_gap = $urandom_range(1, 10);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COLS: grid_cols = val & 7'h7F;
			REG_ROWS: grid_rows = val & 7'h7F;
			REG_INV_X: scale_x = val;
			REG_INV_Y: scale_y = val;
			REG_R_FLOOR: field_min = val;
			default: ;
		endcase
	endtask

	task automatic set_grid(int c, int r, int ix, int iy, int fl);
		write_reg(REG_COLS, CFG_DATA_W'(c));
		write_reg(REG_ROWS, CFG_DATA_W'(r));
		write_reg(REG_INV_X, CFG_DATA_W'(ix));
		write_reg(REG_INV_Y, CFG_DATA_W'(iy));
		write_reg(REG_R_FLOOR, CFG_DATA_W'(fl));
	endtask

	// Loads cause no result, so allow the back end to finish after the queue runs dry.
	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_ops.size() != 0 || push || expected_accel.size() != 0)
			&& guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
	endtask

	function automatic particle_op_t load_op(int a, logic signed [31:0] v);
		particle_op_t it;
		it = '{FUNC_LOAD, a[11:0], v, $urandom, $urandom, $urandom, $urandom};
		return it;
	endfunction

	function automatic particle_op_t query_op(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] vx, logic signed [31:0] vy);
		particle_op_t it;
		it = '{FUNC_QUERY, 12'($urandom), 32'($urandom), px, py, vx, vy};
		return it;
	endfunction

	function automatic logic signed [31:0] rand_pos(longint n);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 131072)) - 65536;
			default: return $signed($urandom_range(0, (n + 2) * 65536)) - 65536;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_vel();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return $signed($urandom_range(0, 262144)) - 131072;
	endfunction

	function automatic logic signed [31:0] rand_sample();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
	endfunction

	task automatic random_phase(int count);
		longint nc, nr;
		nc = clip(grid_cols, 3, 64);
		nr = clip(grid_rows, 3, 64);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				pending_ops.push_back(load_op($urandom_range(0, 4095), rand_sample()));
			else
				pending_ops.push_back(query_op(rand_pos(nc), rand_pos(nr),
					rand_vel(), rand_vel()));
		end
		drain();
	endtask

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_grid(64, 16, 65536, 65536, 66);
		// Every entry that any grid below can reach is written at least once, so all
		// queries read defined samples.
		for (int a = 0; a < 1024; a++)
			pending_ops.push_back(load_op(a, rand_sample()));
		pending_ops.push_back(load_op(0, 32'sh7FFFFFFF));
		pending_ops.push_back(load_op(1, 32'sh80000000));
		pending_ops.push_back(load_op(4095, 32'sh80000000));
		pending_ops.push_back(load_op(64, 32'sh7FFFFFFF));
		pending_ops.push_back(query_op(0, 0, 0, 0));
		pending_ops.push_back(query_op(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
		pending_ops.push_back(query_op(32'sh80000000, 32'sh80000000, 65536, 65536));
		pending_ops.push_back(query_op(32'sh00008000, 32'sh00008000, 32'sh7FFFFFFF, 0));
		pending_ops.push_back(query_op(-32'sh00008000, 32'sh00018000, 0, 32'sh80000000));
		pending_ops.push_back(query_op(32'sh00014000, 32'sh00010000,
			32'sh7FFFFFFF, 32'sh80000000));
		pending_ops.push_back(query_op(32'sh003F0000, 32'sh003F0000, -65536, 98304));
		pending_ops.push_back(query_op(32'sh00200000, 32'sh00280000, 32'sh00010000, 0));
		drain();
		random_phase(150);
		set_grid(3, 3, 65536, 65536, 1);
		pending_ops.push_back(query_op(32'sh00020000, 32'sh00020000, 0, 0));
		random_phase(150);
		set_grid(127, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
		random_phase(120);
		set_grid(20, 40, 0, 0, 0);
		random_phase(120);
		set_grid(17, 40, 32768, 131072, 1 << 20);
		random_phase(120);
		calm = 1'b1;
		set_grid(64, 16, 65536, 65536, 66);
		random_phase(200);
		if (mismatches == 0 && expected_accel.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
